// File: sv/bfb_pkg.sv
// Package for the byte frame builder: beat types, byte kind and status codes.
// Used by byte_frame_builder; depends on nothing else.
`default_nettype none

package bfb_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned LenW  = 16;
	localparam int unsigned MaxBeats = 4;
	localparam int unsigned BeatIdxW = 2;

	typedef enum logic {
		OP_START   = 1'b0,
		OP_PAYLOAD = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		KIND_ID       = 3'd0,
		KIND_LEN_LO   = 3'd1,
		KIND_LEN_HI   = 3'd2,
		KIND_PAYLOAD  = 3'd3,
		KIND_CHECKSUM = 3'd4,
		KIND_NONE     = 3'd5
	} byte_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BUSY     = 2'd1,
		ST_NO_FRAME = 2'd2
	} status_t;

	typedef struct packed {
		op_t               operation;
		logic [LenW-1:0]   frame_length;
		logic [ByteW-1:0]  payload_byte;
	} in_item_t;

	typedef struct packed {
		logic [ByteW-1:0]  out_byte;
		byte_kind_t        byte_kind;
		status_t           status;
		logic              frame_done;
		logic              last;
	} out_item_t;

endpackage

`default_nettype wire

// File: sv/byte_frame_builder.sv
// Byte frame builder: length-prefixed frames with an 8-bit additive checksum.
// The first result beat passes through the burst stage, then the output register.
// Result beats leave one per cycle while result_ready allows; an item holds the burst stage
// until all of its results have moved on (payload 1 or 2, start 3 or 4, refusal 1).
// Reset (arst_n low, asynchronous): no frame open, sum and count cleared,
// frame_id 0, both pipeline stages empty; depends on bfb_pkg.
`default_nettype none

module byte_frame_builder (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// item channel
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire bfb_pkg::in_item_t  item,
	// result channel
	output logic                    result_valid,
	input  wire logic               result_ready,
	output bfb_pkg::out_item_t      result,
	// frame_id register write
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [7:0]         cfg_data
);

	// Architectural state of the frame
	logic [bfb_pkg::ByteW-1:0]    frame_id_q;
	logic                         frame_open_q;
	logic [bfb_pkg::LenW-1:0]     bytes_left_q;
	logic [bfb_pkg::ByteW-1:0]    running_sum_q;

	// Burst stage: all result beats of the current item, read out one a cycle as load_out allows
	bfb_pkg::out_item_t           beats_s1 [bfb_pkg::MaxBeats];
	logic [bfb_pkg::BeatIdxW-1:0] last_idx_s1;
	logic [bfb_pkg::BeatIdxW-1:0] idx_s1;
	logic                         valid_s1;

	// Output register
	bfb_pkg::out_item_t           result_q;
	logic                         result_valid_q;

	// Next-state and burst contents for the item at the input
	bfb_pkg::out_item_t           beats_d [bfb_pkg::MaxBeats];
	logic [bfb_pkg::BeatIdxW-1:0] last_idx_d;
	logic                         frame_open_d;
	logic [bfb_pkg::LenW-1:0]     bytes_left_d;
	logic [bfb_pkg::ByteW-1:0]    running_sum_d;
	logic [bfb_pkg::ByteW-1:0]    sum_new;
	logic                         final_payload;

	logic item_take;
	logic load_out;
	logic beat_final;

	assign cfg_ready = 1'b1;

	// Output register advances when empty or when its beat is taken
	assign load_out   = !result_valid_q || result_ready;
	assign beat_final = (idx_s1 == last_idx_s1);
	// Burst stage frees as its final beat moves to the output register
	assign item_ready = !valid_s1 || (load_out && beat_final);
	assign item_take  = item_valid && item_ready;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign sum_new       = running_sum_q + item.payload_byte;
	// bytes_left is never zero while a frame is open
	assign final_payload = (bytes_left_q == bfb_pkg::LenW'(1));

	always_comb begin
		for (int i = 0; i < bfb_pkg::MaxBeats; i++) begin
			beats_d[i] = '{
				out_byte:   '0,
				byte_kind:  bfb_pkg::KIND_NONE,
				status:     bfb_pkg::ST_OK,
				frame_done: 1'b0,
				last:       1'b0
			};
		end
		last_idx_d    = '0;
		frame_open_d  = frame_open_q;
		bytes_left_d  = bytes_left_q;
		running_sum_d = running_sum_q;

		case (item.operation)
			bfb_pkg::OP_START: begin
				if (frame_open_q) begin
					beats_d[0].status = bfb_pkg::ST_BUSY;
					beats_d[0].last   = 1'b1;
				end else begin
					running_sum_d = '0;
					bytes_left_d  = item.frame_length;
					beats_d[0].out_byte  = frame_id_q;
					beats_d[0].byte_kind = bfb_pkg::KIND_ID;
					beats_d[1].out_byte  = item.frame_length[7:0];
					beats_d[1].byte_kind = bfb_pkg::KIND_LEN_LO;
					beats_d[2].out_byte  = item.frame_length[15:8];
					beats_d[2].byte_kind = bfb_pkg::KIND_LEN_HI;
					if (item.frame_length == '0) begin
						// empty frame: header then a zero checksum, stays closed
						beats_d[3].byte_kind  = bfb_pkg::KIND_CHECKSUM;
						beats_d[3].frame_done = 1'b1;
						beats_d[3].last       = 1'b1;
						last_idx_d            = bfb_pkg::BeatIdxW'(3);
						frame_open_d          = 1'b0;
					end else begin
						beats_d[2].last = 1'b1;
						last_idx_d      = bfb_pkg::BeatIdxW'(2);
						frame_open_d    = 1'b1;
					end
				end
			end
			bfb_pkg::OP_PAYLOAD: begin
				if (!frame_open_q) begin
					beats_d[0].status = bfb_pkg::ST_NO_FRAME;
					beats_d[0].last   = 1'b1;
				end else begin
					bytes_left_d         = bytes_left_q - bfb_pkg::LenW'(1);
					running_sum_d        = sum_new;
					beats_d[0].out_byte  = item.payload_byte;
					beats_d[0].byte_kind = bfb_pkg::KIND_PAYLOAD;
					if (final_payload) begin
						beats_d[1].out_byte   = sum_new;
						beats_d[1].byte_kind  = bfb_pkg::KIND_CHECKSUM;
						beats_d[1].frame_done = 1'b1;
						beats_d[1].last       = 1'b1;
						last_idx_d            = bfb_pkg::BeatIdxW'(1);
						frame_open_d          = 1'b0;
						running_sum_d         = '0;
					end else begin
						beats_d[0].last = 1'b1;
					end
				end
			end
			default: begin
				beats_d[0].last = 1'b1;
			end
		endcase
	end

	// Register file and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_id_q    <= '0;
			frame_open_q  <= 1'b0;
			bytes_left_q  <= '0;
			running_sum_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				frame_id_q <= cfg_data;
			end
			if (item_take) begin
				frame_open_q  <= frame_open_d;
				bytes_left_q  <= bytes_left_d;
				running_sum_q <= running_sum_d;
			end
		end
	end

	// Burst stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
		end else begin
			if (item_take) begin
				valid_s1 <= 1'b1;
				idx_s1   <= '0;
			end else if (valid_s1 && load_out) begin
				if (beat_final) begin
					valid_s1 <= 1'b0;
					idx_s1   <= '0;
				end else begin
					idx_s1 <= idx_s1 + bfb_pkg::BeatIdxW'(1);
				end
			end
		end
	end

	// Burst payload, no reset needed
	always_ff @(posedge clk) begin
		if (item_take) begin
			beats_s1    <= beats_d;
			last_idx_s1 <= last_idx_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out && valid_s1) begin
			result_q <= beats_s1[idx_s1];
		end
	end

	// Checks
	a_done_is_checksum: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.frame_done |->
			result_q.byte_kind == bfb_pkg::KIND_CHECKSUM && result_q.last)
		else $error("frame_done on a beat that is not a closing checksum");

	a_refusal_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.status != bfb_pkg::ST_OK |->
			result_q.byte_kind == bfb_pkg::KIND_NONE && result_q.last)
		else $error("refusal beat carries a byte or is not last");

	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> idx_s1 <= last_idx_s1)
		else $error("burst index ran past the final beat");

	a_closed_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_open_q |-> bytes_left_q == '0)
		else $error("bytes remain with no frame open");

	a_open_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_open_q |-> bytes_left_q != '0)
		else $error("frame open with nothing left to send");

endmodule

`default_nettype wire
